// ----- rtl/first_match_packet_rule_filter_macros.svh -----
// Assertion macros for the packet rule filter.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FIRST_MATCH_PACKET_RULE_FILTER_MACROS_SVH
`define FIRST_MATCH_PACKET_RULE_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FMPRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FMPRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FMPRF_ASSERT_IMP(label, ante, cons, msg)
`define FMPRF_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/fmprf_pkg.sv -----
`default_nettype none

package fmprf_pkg;

  // Table size and derived widths
  localparam int MAX_RULES = 64;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int PROTO_W   = 8;
  localparam int DIR_W     = 2;
  localparam int PORT_W    = 16;
  localparam int ADDR_W    = 32;
  localparam int VERDICT_W = 2;
  localparam int RIDX_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_ALLOW = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DENY  = 2'd1;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_IN  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_OUT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_ANY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NET_DENY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 1'b1;

  // One stored rule (61 bits)
  typedef struct packed {
    logic [PROTO_W-1:0]   proto;
    logic                 any_proto;
    logic [DIR_W-1:0]     dir;
    logic [PORT_W-1:0]    port;
    logic [ADDR_W-1:0]    addr;
    logic [VERDICT_W-1:0] verdict;
  } rule_t;

  // Rule write broadcast to the cells
  typedef struct packed {
    logic  en;
    rule_t rule;
  } wr_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic [PROTO_W-1:0]   proto;
    logic [DIR_W-1:0]     dir;
    logic [PORT_W-1:0]    port;
    logic [ADDR_W-1:0]    addr;
    logic                 hit;
    logic [VERDICT_W-1:0] verdict;
    logic [IDX_W-1:0]     idx;
  } srch_t;

endpackage

`default_nettype wire

// ----- rtl/fmprf_if.sv -----
`default_nettype none

// Request channel
interface fmprf_in_if;
  import fmprf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic                 both_ipv4;
  logic [PROTO_W-1:0]   proto;
  logic                 proto_any;
  logic [DIR_W-1:0]     direction;
  logic [PORT_W-1:0]    port;
  logic [ADDR_W-1:0]    addr;
  logic [VERDICT_W-1:0] rule_verdict;

  modport source (output valid, op, both_ipv4, proto, proto_any, direction, port, addr,
                  rule_verdict, input ready);
  modport sink   (input valid, op, both_ipv4, proto, proto_any, direction, port, addr,
                  rule_verdict, output ready);
endinterface

// Result channel
interface fmprf_out_if;
  import fmprf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 hit;
  logic [RIDX_W-1:0]    rule_index;
  logic                 status;

  modport source (output valid, verdict, hit, rule_index, status, input ready);
  modport sink   (input valid, verdict, hit, rule_index, status, output ready);
endinterface

// Configuration write channel
interface fmprf_cfg_if;
  import fmprf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fmprf_cell.sv -----
`default_nettype none

module fmprf_cell import fmprf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [CNT_W-1:0] rule_count,
  input  wr_t              wr,
  input  srch_t            srch_in,
  output srch_t            srch_out
);

  rule_t rule_r;
  srch_t srch_r;
  srch_t srch_nxt;
  logic  active;
  logic  proto_ok;
  logic  dir_ok;
  logic  key_ok;
  logic  match;

  // Rule storage: written when this cell is the next free slot
  always_ff @(posedge clk) begin
    if (wr.en && (CNT_W'(cell_idx) == rule_count)) begin
      rule_r <= wr.rule;
    end
  end

  // Match this cell's rule against the passing request
  assign active   = CNT_W'(cell_idx) < rule_count;
  assign proto_ok = rule_r.any_proto || (rule_r.proto == srch_in.proto);
  assign dir_ok   = (rule_r.dir == DIR_ANY) || (rule_r.dir == srch_in.dir);
  assign key_ok   = ((srch_in.dir == DIR_IN) && (rule_r.port == srch_in.port)) ||
                    ((srch_in.dir == DIR_OUT) && (rule_r.addr == srch_in.addr));
  assign match    = active && proto_ok && dir_ok && key_ok;

  // First hit along the chain wins; later cells leave it alone
  always_comb begin
    srch_nxt = srch_in;
    if (srch_in.valid && !srch_in.hit && match) begin
      srch_nxt.hit     = 1'b1;
      srch_nxt.verdict = rule_r.verdict;
      srch_nxt.idx     = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r <= '0;
    end else begin
      srch_r <= srch_nxt;
    end
  end

  assign srch_out = srch_r;

endmodule

`default_nettype wire

// ----- rtl/first_match_packet_rule_filter.sv -----
// First-match packet rule filter. Rules sit one to a cell in a chain of
// MAX_RULES cells; append writes the next free cell, clear resets the rule
// count. A classify request that needs the rule table walks the chain one
// cell per clock through the cell registers and then the output register,
// and no new request is taken until its result has left the chain.
// Append, clear, unused op codes, and classify requests decided by
// net_deny, filter_enable or the IPv4 flag answer in the cycle after they
// are accepted, and a new item is taken while the previous result is being
// consumed. Configuration writes are always accepted and must only happen
// while the block is idle.
`default_nettype none

`include "first_match_packet_rule_filter_macros.svh"

module first_match_packet_rule_filter import fmprf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  fmprf_in_if.sink           in_ch,
  fmprf_out_if.source        out_ch,
  fmprf_cfg_if.sink          cfg_ch
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_RULES);

  logic                 net_deny_r;
  logic                 filter_en_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 busy_r;
  logic                 busy_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [VERDICT_W-1:0] out_verdict_r;
  logic [VERDICT_W-1:0] out_verdict_nxt;
  logic                 out_hit_r;
  logic                 out_hit_nxt;
  logic [IDX_W-1:0]     out_idx_r;
  logic [IDX_W-1:0]     out_idx_nxt;
  logic                 out_status_r;
  logic                 out_status_nxt;

  logic                 in_ready;
  logic                 in_acc;
  logic                 lookup;
  logic                 full;
  logic [VERDICT_W-1:0] imm_verdict;
  logic                 imm_status;
  wr_t                  wr;
  srch_t                link [MAX_RULES+1];
  srch_t                tail;

  // Handshake: one lookup in flight, output slot must be free or draining
  assign in_ready    = !busy_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign full        = (count_r == FULL_CNT);
  assign lookup      = (in_ch.op == OP_CLASSIFY) && !net_deny_r && filter_en_r &&
                       in_ch.both_ipv4;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_deny_r  <= 1'b0;
      filter_en_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_NET_DENY:  net_deny_r  <= cfg_ch.data[0];
        CFG_FILTER_EN: filter_en_r <= cfg_ch.data[0];
        default:       ;
      endcase
    end
  end

  // Rule write into the next free cell
  always_comb begin
    wr.en             = in_acc && (in_ch.op == OP_APPEND) && !full;
    wr.rule.proto     = in_ch.proto;
    wr.rule.any_proto = in_ch.proto_any;
    wr.rule.dir       = in_ch.direction;
    wr.rule.port      = in_ch.port;
    wr.rule.addr      = in_ch.addr;
    wr.rule.verdict   = in_ch.rule_verdict;
  end

  // Rule count
  always_comb begin
    count_nxt = count_r;
    if (wr.en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (in_acc && (in_ch.op == OP_CLEAR)) begin
      count_nxt = '0;
    end
  end

  // Search token entering the chain; default answer is deny with no hit
  always_comb begin
    link[0].valid   = in_acc && lookup;
    link[0].proto   = in_ch.proto;
    link[0].dir     = in_ch.direction;
    link[0].port    = in_ch.port;
    link[0].addr    = in_ch.addr;
    link[0].hit     = 1'b0;
    link[0].verdict = VERDICT_DENY;
    link[0].idx     = '0;
  end

  // Chain of rule cells
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    fmprf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(i)),
      .rule_count (count_r),
      .wr         (wr),
      .srch_in    (link[i]),
      .srch_out   (link[i+1])
    );
  end

  assign tail = link[MAX_RULES];

  // Answers that need no rule lookup
  always_comb begin
    imm_verdict = VERDICT_ALLOW;
    imm_status  = 1'b0;
    unique case (in_ch.op)
      OP_CLASSIFY: begin
        if (net_deny_r) begin
          imm_verdict = VERDICT_DENY;
        end else if (!filter_en_r) begin
          imm_verdict = VERDICT_ALLOW;
        end else begin
          imm_verdict = VERDICT_DENY;
        end
      end
      OP_APPEND: imm_status = full;
      default:   ;
    endcase
  end

  // Output register and busy flag
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_verdict_nxt = out_verdict_r;
    out_hit_nxt     = out_hit_r;
    out_idx_nxt     = out_idx_r;
    out_status_nxt  = out_status_r;
    busy_nxt        = busy_r;
    if (tail.valid) begin
      out_valid_nxt   = 1'b1;
      out_verdict_nxt = tail.verdict;
      out_hit_nxt     = tail.hit;
      out_idx_nxt     = tail.idx;
      out_status_nxt  = 1'b0;
      busy_nxt        = 1'b0;
    end else if (in_acc && lookup) begin
      busy_nxt = 1'b1;
    end else if (in_acc) begin
      out_valid_nxt   = 1'b1;
      out_verdict_nxt = imm_verdict;
      out_hit_nxt     = 1'b0;
      out_idx_nxt     = '0;
      out_status_nxt  = imm_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
    out_hit_r     <= out_hit_nxt;
    out_idx_r     <= out_idx_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.verdict    = out_verdict_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.rule_index = RIDX_W'(out_idx_r);
  assign out_ch.status     = out_status_r;

  // Checks
  `FMPRF_ASSERT_IMP(a_tail_needs_busy, tail.valid, busy_r,
    "search result left the chain with no lookup in flight")
  `FMPRF_ASSERT_IMP(a_count_bound, 1'b1, count_r <= FULL_CNT,
    "rule count exceeds table size")
  `FMPRF_ASSERT_NXT(a_append_counts, wr.en, count_r == $past(count_r) + CNT_W'(1),
    "append did not advance the rule count")
  `FMPRF_ASSERT_IMP(a_hit_in_table, out_valid_r && out_hit_r,
    CNT_W'(out_idx_r) < count_r, "hit reported on a rule beyond the table end")

endmodule

`default_nettype wire

// ----- verif/fmprf_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and register channels of the rule filter,
// keeps its own copy of the rule table and flags every result that differs
// from the predicted answer.
module fmprf_checker import fmprf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fmprf_in_if  in_ch,
  fmprf_out_if out_ch,
  fmprf_cfg_if cfg_ch,
  output int   mismatches,
  output int   answers_pending
);

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic                 hit;
    logic [RIDX_W-1:0]    rule_index;
    logic                 status;
  } answer_t;

  // Shadow of the block's state and registers
  rule_t       rules [MAX_RULES];
  int unsigned rule_cnt;
  logic        deny_all;
  logic        filtering;

  answer_t answers_due[$];
  int      err_count = 0;
  int      pending_q = 0;

  assign mismatches      = err_count;
  assign answers_pending = pending_q;

  // Applies one request to the shadow table and returns the answer it earns
  function automatic answer_t filter_answer(
    logic [OP_W-1:0]      op,
    logic                 ipv4,
    logic [PROTO_W-1:0]   proto,
    logic                 pany,
    logic [DIR_W-1:0]     dir,
    logic [PORT_W-1:0]    port,
    logic [ADDR_W-1:0]    addr,
    logic [VERDICT_W-1:0] rv
  );
    answer_t a;
    rule_t   r;
    logic    key_ok;
    a = '0;
    unique case (op)
      OP_CLASSIFY: begin
        if (deny_all) begin
          a.verdict = VERDICT_DENY;
        end else if (!filtering) begin
          a.verdict = VERDICT_ALLOW;
        end else begin
          a.verdict = VERDICT_DENY;
          // non-IPv4 traffic never reaches the table
          if (ipv4) begin
            for (int i = 0; i < rule_cnt; i++) begin
              r = rules[i];
              key_ok = (dir == DIR_IN && r.port == port) ||
                       (dir == DIR_OUT && r.addr == addr);
              if (!a.hit && (r.any_proto || r.proto == proto) &&
                  (r.dir == DIR_ANY || r.dir == dir) && key_ok) begin
                a.hit        = 1'b1;
                a.verdict    = r.verdict;
                a.rule_index = RIDX_W'(i);
              end
            end
          end
        end
      end
      OP_APPEND: begin
        if (rule_cnt >= MAX_RULES) begin
          a.status = 1'b1;
        end else begin
          r.proto          = proto;
          r.any_proto      = pany;
          r.dir            = dir;
          r.port           = port;
          r.addr           = addr;
          r.verdict        = rv;
          rules[rule_cnt]  = r;
          rule_cnt++;
        end
      end
      OP_CLEAR: rule_cnt = 0;
      default: ;
    endcase
    return a;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Results are compared before the same edge's request is queued
  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      rule_cnt  = 0;
      deny_all  = 1'b0;
      filtering = 1'b0;
      answers_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          $error("result item with no request waiting");
          err_count++;
        end else begin
          want = answers_due.pop_front();
          check_field("verdict", want.verdict, out_ch.verdict);
          check_field("hit", want.hit, out_ch.hit);
          check_field("rule_index", want.rule_index, out_ch.rule_index);
          check_field("status", want.status, out_ch.status);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_NET_DENY:  deny_all  = cfg_ch.data[0];
          CFG_FILTER_EN: filtering = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        answers_due.push_back(filter_answer(in_ch.op, in_ch.both_ipv4, in_ch.proto,
                                            in_ch.proto_any, in_ch.direction, in_ch.port,
                                            in_ch.addr, in_ch.rule_verdict));
      end
    end
    pending_q <= answers_due.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fmprf_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
  localparam logic [DIR_W-1:0] DIR_NONE     = 2'd3;
  localparam int               LIMIT_CYCLES = 1_000_000;
  localparam int               BLOCK_ITEMS  = 250;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   items_sent;

  fmprf_in_if  in_ch();
  fmprf_out_if out_ch();
  fmprf_cfg_if cfg_ch();

  first_match_packet_rule_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fmprf_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .mismatches      (mismatches),
    .answers_pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("[first_match_packet_rule_filter] ERROR");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Small value pools so that requests collide with stored rules
  function automatic logic [PROTO_W-1:0] pick_proto();
    case ($urandom_range(5))
      0: return '0;
      1: return 8'd6;
      2: return 8'd17;
      3: return '1;
      default: return PROTO_W'($urandom);
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'd80;
      3: return 16'd443;
      4: return 16'h8000;
      default: return PORT_W'($urandom);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h0A00_0001;
      3: return 32'h8000_0000;
      4: return 32'hC0A8_0101;
      default: return $urandom;
    endcase
  endfunction

  // One request item, with a random gap in front of it
  task automatic send(
    logic [OP_W-1:0]      op,
    logic                 ipv4,
    logic [PROTO_W-1:0]   proto,
    logic                 pany,
    logic [DIR_W-1:0]     dir,
    logic [PORT_W-1:0]    port,
    logic [ADDR_W-1:0]    addr,
    logic [VERDICT_W-1:0] rv
  );
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.both_ipv4    <= ipv4;
    in_ch.proto        <= proto;
    in_ch.proto_any    <= pany;
    in_ch.direction    <= dir;
    in_ch.port         <= port;
    in_ch.addr         <= addr;
    in_ch.rule_verdict <= rv;
    do @(posedge clk); while (!in_ch.ready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Drop valid and wait until every answer is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Both registers in one back-to-back burst
  task automatic write_regs(logic deny, logic enable);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_NET_DENY;
    cfg_ch.data  <= deny;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_FILTER_EN;
    cfg_ch.data  <= enable;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Optional clear, a run of appends, then lookups against them
  task automatic rule_scenario();
    int               n_rules;
    int               n_reqs;
    logic [DIR_W-1:0] d;
    if ($urandom_range(1))
      send(OP_CLEAR, 1'($urandom), PROTO_W'($urandom), 1'($urandom), DIR_W'($urandom),
           PORT_W'($urandom), $urandom, VERDICT_W'($urandom));
    // now and then fill past the end of the table
    n_rules = ($urandom_range(9) == 0) ? $urandom_range(70, 55) : $urandom_range(6);
    n_reqs  = $urandom_range(12, 4);
    repeat (n_rules) begin
      case ($urandom_range(9))
        0, 1, 2, 3: d = DIR_IN;
        4, 5, 6:    d = DIR_OUT;
        7, 8:       d = DIR_ANY;
        default:    d = DIR_NONE;
      endcase
      send(OP_APPEND, 1'($urandom), pick_proto(), ($urandom_range(3) == 0), d,
           pick_port(), pick_addr(), VERDICT_W'($urandom));
    end
    repeat (n_reqs) begin
      if ($urandom_range(19) == 0)
        send(OP_UNUSED, 1'($urandom), PROTO_W'($urandom), 1'($urandom), DIR_W'($urandom),
             PORT_W'($urandom), $urandom, VERDICT_W'($urandom));
      case ($urandom_range(9))
        0, 1, 2, 3, 4: d = DIR_IN;
        5, 6, 7, 8:    d = DIR_OUT;
        default:       d = DIR_W'($urandom_range(3, 2));
      endcase
      send(OP_CLASSIFY, ($urandom_range(9) != 0), pick_proto(), 1'($urandom), d,
           pick_port(), pick_addr(), VERDICT_W'($urandom));
    end
  endtask

  initial begin
    items_sent         = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_CLASSIFY;
    in_ch.both_ipv4    <= 1'b0;
    in_ch.proto        <= '0;
    in_ch.proto_any    <= 1'b0;
    in_ch.direction    <= DIR_IN;
    in_ch.port         <= '0;
    in_ch.addr         <= '0;
    in_ch.rule_verdict <= VERDICT_ALLOW;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_NET_DENY;
    cfg_ch.data        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: table lookups with filtering on
    write_regs(1'b0, 1'b1);
    send(OP_CLASSIFY, 1'b1, 8'd6, 1'b0, DIR_IN, 16'd80, 32'h0, VERDICT_ALLOW);
    send(OP_APPEND, 1'b1, 8'd6, 1'b0, DIR_IN, 16'h0000, 32'h0, VERDICT_ALLOW);
    send(OP_APPEND, 1'b0, 8'd0, 1'b1, DIR_OUT, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send(OP_APPEND, 1'b1, 8'hFF, 1'b0, DIR_ANY, 16'hFFFF, 32'h0, 2'd2);
    send(OP_APPEND, 1'b1, 8'd17, 1'b1, DIR_NONE, 16'd80, 32'h8000_0000, VERDICT_DENY);
    send(OP_CLASSIFY, 1'b1, 8'd6, 1'b0, DIR_IN, 16'h0000, 32'h1234_5678, 2'd3);
    send(OP_CLASSIFY, 1'b1, 8'h55, 1'b1, DIR_OUT, 16'd1, 32'hFFFF_FFFF, VERDICT_ALLOW);
    send(OP_CLASSIFY, 1'b1, 8'hFF, 1'b0, DIR_IN, 16'hFFFF, 32'h0, VERDICT_ALLOW);
    send(OP_CLASSIFY, 1'b1, 8'hFF, 1'b0, DIR_OUT, 16'h0, 32'h0, VERDICT_ALLOW);
    // requests that are neither inbound nor outbound never match
    send(OP_CLASSIFY, 1'b1, 8'd17, 1'b0, DIR_ANY, 16'd80, 32'h8000_0000, VERDICT_ALLOW);
    send(OP_CLASSIFY, 1'b1, 8'd17, 1'b0, DIR_NONE, 16'd80, 32'h8000_0000, VERDICT_ALLOW);
    // non-IPv4 is denied even when a rule would match
    send(OP_CLASSIFY, 1'b0, 8'd6, 1'b0, DIR_IN, 16'h0000, 32'h0, VERDICT_ALLOW);
    send(OP_CLASSIFY, 1'b1, 8'd7, 1'b0, DIR_IN, 16'h0000, 32'h0, VERDICT_ALLOW);
    send(OP_UNUSED, 1'b1, 8'hFF, 1'b1, DIR_NONE, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send(OP_CLEAR, 1'b1, 8'hFF, 1'b1, DIR_NONE, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
    send(OP_CLASSIFY, 1'b1, 8'd6, 1'b0, DIR_IN, 16'h0000, 32'h0, VERDICT_ALLOW);
    send(OP_APPEND, 1'b1, 8'd6, 1'b0, DIR_IN, 16'h0000, 32'h0, 2'd3);
    send(OP_CLASSIFY, 1'b1, 8'd6, 1'b0, DIR_IN, 16'h0000, 32'h0, VERDICT_ALLOW);

    // Random: blocks of register settings and idling modes
    for (int b = 0; b < 8; b++) begin
      settle();
      write_regs((b == 1 || b == 5), !(b == 3 || b == 5));
      case (b % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      items_sent = 0;
      while (items_sent < BLOCK_ITEMS) rule_scenario();
    end

    // Drain, then give stray results time to show up
    settle();
    repeat (MAX_RULES + 8) @(posedge clk);
    if (mismatches == 0)
      $display("[first_match_packet_rule_filter] OK");
    else
      $display("[first_match_packet_rule_filter] ERROR");
    $finish;
  end

endmodule
